[src/adb_keyboard_event_device_top_macros.svh]
// ----------------------------------------------------------------------------
// adb keyboard event device - assertion macros
// concurrent assertion helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef ADB_KEYBOARD_EVENT_DEVICE_TOP_MACROS_SVH
`define ADB_KEYBOARD_EVENT_DEVICE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, idle during reset
`define ADBKBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// next-cycle implication
`define ADBKBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define ADBKBD_ASSERT_IMPL(label, ante, cons)
`define ADBKBD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/adbkbd_pkg.sv]
// ----------------------------------------------------------------------------
// adbkbd_pkg
// shared types, constants and helpers of the adb keyboard event device
// ----------------------------------------------------------------------------
`default_nettype none

package adbkbd_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int KEY_COUNT  = 128;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int KEY_W      = $clog2(KEY_COUNT);

  typedef enum logic [1:0] {
    REQ_KEY       = 2'd0,
    REQ_RELEASE   = 2'd1,
    REQ_BUS       = 2'd2,
    REQ_LED_DATA  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_RESET  = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_TALK   = 2'd2,
    CMD_LISTEN = 2'd3
  } bus_cmd_t;

  localparam logic [1:0] REG_EVENTS = 2'd0;
  localparam logic [1:0] REG_MODS   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_POP1,
    ST_POP2,
    ST_RESULT
  } state_t;

  // scan codes with a modifier bit
  localparam logic [6:0] KEY_DELETE    = 7'h75;
  localparam logic [6:0] KEY_CAPS      = 7'h39;
  localparam logic [6:0] KEY_POWER     = 7'h7f;
  localparam logic [6:0] KEY_CTRL_L    = 7'h36;
  localparam logic [6:0] KEY_CTRL_R    = 7'h7d;
  localparam logic [6:0] KEY_SHIFT_L   = 7'h38;
  localparam logic [6:0] KEY_SHIFT_R   = 7'h7b;
  localparam logic [6:0] KEY_OPTION_L  = 7'h3a;
  localparam logic [6:0] KEY_OPTION_R  = 7'h7c;
  localparam logic [6:0] KEY_COMMAND   = 7'h37;
  localparam logic [6:0] KEY_CLEAR     = 7'h47;
  localparam logic [6:0] KEY_HELP      = 7'h72;

  localparam logic [15:0] MOD_DELETE   = 16'h4000;
  localparam logic [15:0] MOD_CAPS     = 16'h2000;
  localparam logic [15:0] MOD_POWER    = 16'h1000;
  localparam logic [15:0] MOD_CTRL     = 16'h0800;
  localparam logic [15:0] MOD_SHIFT    = 16'h0400;
  localparam logic [15:0] MOD_OPTION   = 16'h0200;
  localparam logic [15:0] MOD_COMMAND  = 16'h0100;
  localparam logic [15:0] MOD_CLEAR    = 16'h0080;
  localparam logic [15:0] MOD_HELP     = 16'h0040;
  localparam logic [15:0] MOD_ALL_UP   = 16'hffff;
  localparam logic [15:0] MOD_KEYS_UP  = 16'hfff8;
  localparam logic [7:0]  RESP_PAD     = 8'h80;

  typedef struct packed {
    logic capture;
    logic key_apply;
    logic led_apply;
    logic disarm;
    logic arm;
    logic dev_reset;
    logic fifo_clear;
    logic hold_mod;
    logic scan_step;
    logic pop_first;
    logic pad_lo;
    logic rd_next;
    logic pop_second;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t       req;
    bus_cmd_t   bus_cmd;
    logic [1:0] reg_num;
    logic       fifo_empty;
    logic       fifo_one;
    logic       scan_last;
    logic       out_free;
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // active-low: following bits clear on press, toggling bits flip on press
  function automatic logic [15:0] mod_key_update(input logic [15:0] mod,
                                                 input logic [6:0]  key,
                                                 input logic        down);
    logic [15:0] fbit;
    logic [15:0] tbit;
    fbit = '0;
    tbit = '0;
    case (key)
      KEY_DELETE:                fbit = MOD_DELETE;
      KEY_CAPS:                  tbit = MOD_CAPS;
      KEY_POWER:                 fbit = MOD_POWER;
      KEY_CTRL_L, KEY_CTRL_R:     fbit = MOD_CTRL;
      KEY_SHIFT_L, KEY_SHIFT_R:   fbit = MOD_SHIFT;
      KEY_OPTION_L, KEY_OPTION_R: fbit = MOD_OPTION;
      KEY_COMMAND:               fbit = MOD_COMMAND;
      KEY_CLEAR:                 tbit = MOD_CLEAR;
      KEY_HELP:                  tbit = MOD_HELP;
      default:                   fbit = '0;
    endcase
    mod_key_update = down ? ((mod & ~fbit) ^ tbit) : (mod | fbit);
  endfunction

endpackage

`default_nettype wire

[src/adbkbd_ctrl.sv]
// ----------------------------------------------------------------------------
// adbkbd_ctrl
// sequencer: decodes a captured request and steps the datapath through it
// ----------------------------------------------------------------------------
`default_nettype none

module adbkbd_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  adbkbd_pkg::status_t st,
  output adbkbd_pkg::cmd_t    cmd
);
  import adbkbd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (st.req)
          REQ_KEY:      cmd.key_apply = 1'b1;
          REQ_RELEASE:  state_nxt = ST_SCAN;
          REQ_LED_DATA: cmd.led_apply = 1'b1;
          REQ_BUS: begin
            cmd.disarm = 1'b1;
            case (st.bus_cmd)
              CMD_RESET: begin
                cmd.dev_reset  = 1'b1;
                cmd.fifo_clear = 1'b1;
              end
              CMD_FLUSH: cmd.fifo_clear = 1'b1;
              CMD_TALK: begin
                if (st.reg_num == REG_EVENTS) begin
                  // read data for the head entry is ready next cycle
                  if (!st.fifo_empty) state_nxt = ST_POP1;
                end else if (st.reg_num == REG_MODS) begin
                  cmd.hold_mod = 1'b1;
                  state_nxt    = ST_RESULT;
                end
              end
              CMD_LISTEN: cmd.arm = (st.reg_num == REG_MODS);
              default: cmd.disarm = 1'b1;
            endcase
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_nxt = ST_IDLE;
      end
      ST_POP1: begin
        cmd.pop_first = 1'b1;
        if (st.fifo_one) begin
          cmd.pad_lo = 1'b1;
          state_nxt  = ST_RESULT;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = ST_POP2;
        end
      end
      ST_POP2: begin
        cmd.pop_second = 1'b1;
        state_nxt      = ST_RESULT;
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/adbkbd_dp.sv]
// ----------------------------------------------------------------------------
// adbkbd_dp
// event fifo, key map, modifier word, led capture and response register
// ----------------------------------------------------------------------------
`default_nettype none

module adbkbd_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  adbkbd_pkg::cmd_t     cmd,
  output adbkbd_pkg::status_t  st,
  input  wire  [1:0]          req_type,
  input  wire  [6:0]          key_code,
  input  wire                 key_down,
  input  wire  [1:0]          cmd_kind,
  input  wire  [1:0]          reg_num,
  input  wire  [7:0]          led_byte,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          resp_hi,
  output logic [7:0]          resp_lo
);
  import adbkbd_pkg::*;

  // captured request
  logic [1:0]       req_r;
  logic [6:0]       key_r;
  logic             down_r;
  logic [1:0]       cmdk_r;
  logic [1:0]       regn_r;
  logic [7:0]       led_r;

  logic [7:0]       fifo_mem [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] tail_r;
  logic [CNT_W-1:0] count_r;

  logic [KEY_COUNT-1:0] key_map_r;
  logic [KEY_W-1:0]     scan_r;
  logic [15:0]          mod_r;
  logic                 armed_r;

  logic [7:0]       hold_hi_r;
  logic [7:0]       hold_lo_r;
  logic             out_valid_r;
  logic [7:0]       out_hi_r;
  logic [7:0]       out_lo_r;

  logic             push_req;
  logic             push_en;
  logic [7:0]       push_data;
  logic             pop_en;
  logic             full;
  logic [PTR_W-1:0] rd_addr;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign pop_en  = cmd.pop_first | cmd.pop_second;
  assign rd_addr = cmd.rd_next ? ptr_inc(head_r) : head_r;

  always_comb begin
    push_req  = 1'b0;
    push_data = {~down_r, key_r};
    if (cmd.key_apply) begin
      push_req = 1'b1;
    end else if (cmd.scan_step) begin
      push_req  = key_map_r[scan_r];
      push_data = {1'b1, scan_r};
    end
  end

  // a full fifo drops the event
  assign push_en = push_req & ~full;

  always_ff @(posedge clk) begin
    if (push_en) fifo_mem[tail_r] <= push_data;
    rd_data_r <= fifo_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      key_r  <= key_code;
      down_r <= key_down;
      cmdk_r <= cmd_kind;
      regn_r <= reg_num;
      led_r  <= led_byte;
    end
    if (cmd.pop_first) hold_hi_r <= rd_data_r;
    if (cmd.pop_second) hold_lo_r <= rd_data_r;
    if (cmd.pad_lo) hold_lo_r <= RESP_PAD;
    if (cmd.hold_mod) begin
      hold_hi_r <= mod_r[15:8];
      hold_lo_r <= mod_r[7:0];
    end
    if (cmd.out_load) begin
      out_hi_r <= hold_hi_r;
      out_lo_r <= hold_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      key_map_r   <= '0;
      scan_r      <= '0;
      mod_r       <= MOD_ALL_UP;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fifo_clear) begin
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
      end else if (push_en) begin
        tail_r  <= ptr_inc(tail_r);
        count_r <= count_r + CNT_W'(1);
      end else if (pop_en) begin
        head_r  <= ptr_inc(head_r);
        count_r <= count_r - CNT_W'(1);
      end

      if (cmd.capture) scan_r <= '0;
      if (cmd.key_apply) begin
        key_map_r[key_r] <= down_r;
        mod_r            <= mod_key_update(mod_r, key_r, down_r);
      end
      if (cmd.scan_step) begin
        key_map_r[scan_r] <= 1'b0;
        scan_r            <= scan_r + KEY_W'(1);
        if (st.scan_last) mod_r <= mod_r | MOD_KEYS_UP;
      end
      if (cmd.dev_reset) mod_r <= MOD_ALL_UP;

      if (cmd.led_apply && armed_r) begin
        mod_r   <= {mod_r[15:3], led_r[2:0]};
        armed_r <= 1'b0;
      end
      if (cmd.arm) begin
        armed_r <= 1'b1;
      end else if (cmd.disarm) begin
        armed_r <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.req        = req_t'(req_r);
    st.bus_cmd    = bus_cmd_t'(cmdk_r);
    st.reg_num    = regn_r;
    st.fifo_empty = (count_r == '0);
    st.fifo_one   = (count_r == CNT_W'(1));
    st.scan_last  = (scan_r == KEY_W'(KEY_COUNT - 1));
    st.out_free   = ~out_valid_r | out_ready;
  end

  assign out_valid = out_valid_r;
  assign resp_hi   = out_hi_r;
  assign resp_lo   = out_lo_r;

endmodule

`default_nettype wire

[src/adb_keyboard_event_device_top.sv]
// ----------------------------------------------------------------------------
// adb_keyboard_event_device_top
// desktop bus keyboard: event queue, key map, modifier word and bus commands
// ----------------------------------------------------------------------------
// One request is taken at a time. A key change, listen data, reset, flush,
// listen or talk to an empty or unused register is done in the execute state,
// after which the next request can be taken. Talk 2 goes on to the result
// state, and talk 0 reaches it through ST_POP1 (one event) or ST_POP1 and
// ST_POP2 (two events), since each event is read through the registered read
// port of the event fifo memory; a result then waits in the output register
// while the next request is already accepted, and a further result is held
// back until that register is free. Release all scans the key map one key per
// cycle. The event fifo holds FIFO_DEPTH entries; events that find it full
// are lost.
`default_nettype none

`include "adb_keyboard_event_device_top_macros.svh"

module adb_keyboard_event_device_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // key_code[6:0], key_down[7], reg_num[9:8], led_byte[17:10]
  input  wire  [3:0]  in_tuser,   // req_type[1:0], cmd_kind[3:2]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // resp_hi[7:0], resp_lo[15:8]
);
  import adbkbd_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic [7:0] resp_hi;
  logic [7:0] resp_lo;

  adbkbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  adbkbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .req_type  (in_tuser[1:0]),
    .key_code  (in_tdata[6:0]),
    .key_down  (in_tdata[7]),
    .cmd_kind  (in_tuser[3:2]),
    .reg_num   (in_tdata[9:8]),
    .led_byte  (in_tdata[17:10]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .resp_hi   (resp_hi),
    .resp_lo   (resp_lo)
  );

  assign out_tdata = {resp_lo, resp_hi};

  // one request at a time: busy right after acceptance
  `ADBKBD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // a result is never written over one still waiting
  `ADBKBD_ASSERT_IMPL(a_load_only_free, cmd.out_load, st.out_free)
  // events are only popped from a non-empty fifo
  `ADBKBD_ASSERT_IMPL(a_pop_nonempty, cmd.pop_first || cmd.pop_second, !st.fifo_empty)

endmodule

`default_nettype wire

[tb/adb_keyboard_event_device_top_tb.sv]
// ----------------------------------------------------------------------------
// adb_keyboard_event_device_top_tb
// drives key events, release-all, bus commands and listen data into the
// keyboard device and checks every talk response against a predicted queue
// ----------------------------------------------------------------------------
`default_nettype none

module adb_keyboard_event_device_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adbkbd_pkg::*;

  localparam int        TOTAL_REQS   = 1650;
  localparam int        QUIET_TAIL   = 150;
  localparam int        SQUEEZE_AT   = 600;
  localparam int        PAUSE_AT     = 1100;
  localparam int        HOLD_CYCLES  = 400;
  localparam int        SETTLE       = 150;
  localparam int        STALL_LIMIT  = 3000;
  localparam logic [1:0] REG_UNUSED1 = 2'd1;
  localparam logic [1:0] REG_UNUSED3 = 2'd3;

  // keyboard state and the responses it will give to talk requests
  class kbd_event_model;
    logic [7:0]  queue_mem [FIFO_DEPTH];
    int unsigned rd_ptr;
    int unsigned depth_used;
    bit          key_held [KEY_COUNT];
    logic [15:0] mod_word;
    bit          led_armed;
    logic [15:0] pending_resp [$];
    int          errors;

    function new();
      rd_ptr     = 0;
      depth_used = 0;
      mod_word   = MOD_ALL_UP;
      led_armed  = 1'b0;
      errors     = 0;
      foreach (key_held[k]) key_held[k] = 1'b0;
    endfunction

    function void queue_resp(logic [15:0] r);
      pending_resp.insert(pending_resp.size(), r);
    endfunction

    function void push_event(logic [7:0] code);
      if (depth_used < FIFO_DEPTH) begin
        queue_mem[(rd_ptr + depth_used) % FIFO_DEPTH] = code;
        depth_used++;
      end
    endfunction

    function logic [7:0] pop_event();
      logic [7:0] code;
      code       = queue_mem[rd_ptr];
      rd_ptr     = (rd_ptr + 1) % FIFO_DEPTH;
      depth_used--;
      return code;
    endfunction

    function void clear_events();
      rd_ptr     = 0;
      depth_used = 0;
    endfunction

    function void apply_key(logic [6:0] key, logic down);
      logic [15:0] follow;
      logic [15:0] flip;
      follow = '0;
      flip   = '0;
      push_event({~down, key});
      key_held[key] = down;
      case (key)
        KEY_DELETE:                 follow = MOD_DELETE;
        KEY_POWER:                  follow = MOD_POWER;
        KEY_CTRL_L, KEY_CTRL_R:     follow = MOD_CTRL;
        KEY_SHIFT_L, KEY_SHIFT_R:   follow = MOD_SHIFT;
        KEY_OPTION_L, KEY_OPTION_R: follow = MOD_OPTION;
        KEY_COMMAND:                follow = MOD_COMMAND;
        KEY_CAPS:                   flip   = MOD_CAPS;
        KEY_CLEAR:                  flip   = MOD_CLEAR;
        KEY_HELP:                   flip   = MOD_HELP;
        default:                    follow = '0;
      endcase
      // active low: press clears a following bit, release sets it
      if (down) begin
        mod_word = mod_word & ~follow;
        mod_word = mod_word ^ flip;
      end else begin
        mod_word = mod_word | follow;
      end
    endfunction

    function void take_request(logic [23:0] d, logic [3:0] u);
      req_t       rq;
      bus_cmd_t   cmd;
      logic [1:0] rg;
      logic [7:0] first;
      logic [7:0] second;
      rq  = req_t'(u[1:0]);
      cmd = bus_cmd_t'(u[3:2]);
      rg  = d[9:8];
      case (rq)
        REQ_KEY: apply_key(d[6:0], d[7]);
        REQ_RELEASE: begin
          for (int k = 0; k < KEY_COUNT; k++) begin
            if (key_held[k]) begin
              push_event(RESP_PAD | 8'(k));
              key_held[k] = 1'b0;
            end
          end
          mod_word = mod_word | MOD_KEYS_UP;
        end
        REQ_LED_DATA: begin
          if (led_armed) begin
            mod_word  = (mod_word & MOD_KEYS_UP) | {13'b0, d[12:10]};
            led_armed = 1'b0;
          end
        end
        default: begin
          led_armed = 1'b0;
          case (cmd)
            CMD_RESET: begin
              mod_word = MOD_ALL_UP;
              clear_events();
            end
            CMD_FLUSH: clear_events();
            CMD_TALK: begin
              if (rg == REG_EVENTS && depth_used != 0) begin
                first  = pop_event();
                second = (depth_used != 0) ? pop_event() : RESP_PAD;
                queue_resp({second, first});
              end else if (rg == REG_MODS) begin
                queue_resp({mod_word[7:0], mod_word[15:8]});
              end
            end
            default: if (rg == REG_MODS) led_armed = 1'b1;
          endcase
        end
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_response(logic [15:0] got);
      logic [15:0] want;
      if (pending_resp.size() == 0) begin
        report($sformatf("response %h with none outstanding", got));
      end else begin
        want = pending_resp.pop_front();
        if (got[7:0] !== want[7:0])
          report($sformatf("resp_hi got %h want %h", got[7:0], want[7:0]));
        if (got[15:8] !== want[15:8])
          report($sformatf("resp_lo got %h want %h", got[15:8], want[15:8]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  kbd_event_model trk = new();
  int  n_sent      = 0;
  int  idle_cycles = 0;
  bit  quiet       = 1'b0;
  bit  hold_out    = 1'b0;

  always #5 clk = ~clk;

  adb_keyboard_event_device_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) trk.check_response(out_tdata);
      if (in_tvalid && in_tready) trk.take_request(in_tdata, in_tuser);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[adb_keyboard_event_device_top] ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  task automatic send_req(req_t rq, bus_cmd_t cmd, logic [6:0] key, logic down,
                          logic [1:0] rg, logic [7:0] led);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tdata  <= {6'b0, led, rg, down, key};
    in_tuser  <= {cmd, rq};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // called at a falling edge right after an accepted request
  task automatic wait_for_responses();
    in_tvalid <= 1'b0;
    while (trk.pending_resp.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [6:0] pick_key();
    if ($urandom_range(0, 2) != 0) return 7'($urandom_range(0, 127));
    case ($urandom_range(0, 11))
      0:       return KEY_DELETE;
      1:       return KEY_CAPS;
      2:       return KEY_POWER;
      3:       return KEY_CTRL_L;
      4:       return KEY_CTRL_R;
      5:       return KEY_SHIFT_L;
      6:       return KEY_SHIFT_R;
      7:       return KEY_OPTION_L;
      8:       return KEY_OPTION_R;
      9:       return KEY_COMMAND;
      10:      return KEY_CLEAR;
      default: return KEY_HELP;
    endcase
  endfunction

  task automatic random_req();
    int         r;
    logic [6:0] key;
    logic [7:0] led;
    logic [1:0] rg;
    r   = $urandom_range(0, 99);
    key = pick_key();
    led = 8'($urandom_range(0, 255));
    rg  = 2'($urandom_range(0, 3));
    if (r < 42) begin
      send_req(REQ_KEY, bus_cmd_t'($urandom_range(0, 3)), key, ($urandom_range(0, 4) < 3),
               rg, led);
    end else if (r < 62) begin
      send_req(REQ_BUS, CMD_TALK, key, 1'($urandom), REG_EVENTS, led);
    end else if (r < 68) begin
      send_req(REQ_BUS, CMD_TALK, key, 1'($urandom), REG_MODS, led);
    end else if (r < 74) begin
      // listen 2 followed by its led byte
      send_req(REQ_BUS, CMD_LISTEN, key, 1'($urandom), REG_MODS, led);
      send_req(REQ_LED_DATA, bus_cmd_t'($urandom_range(0, 3)), key, 1'($urandom), rg,
               8'($urandom_range(0, 255)));
    end else if (r < 77) begin
      send_req(REQ_LED_DATA, bus_cmd_t'($urandom_range(0, 3)), key, 1'($urandom), rg, led);
    end else if (r < 79) begin
      send_req(REQ_BUS, CMD_RESET, key, 1'($urandom), rg, led);
    end else if (r < 81) begin
      send_req(REQ_BUS, CMD_FLUSH, key, 1'($urandom), rg, led);
    end else if (r < 84) begin
      send_req(REQ_RELEASE, bus_cmd_t'($urandom_range(0, 3)), key, 1'($urandom), rg, led);
    end else if (r < 88) begin
      send_req(REQ_BUS, bus_cmd_t'($urandom_range(2, 3)), key, 1'($urandom),
               ($urandom_range(0, 1) != 0) ? REG_UNUSED1 : REG_UNUSED3, led);
    end else begin
      send_req(req_t'($urandom_range(0, 3)), bus_cmd_t'($urandom_range(0, 3)),
               7'($urandom_range(0, 127)), 1'($urandom), rg, led);
    end
  endtask

  initial begin
    bit squeezed;
    squeezed   = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty talk, extremes of the key code, toggles, leds, clears
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_EVENTS, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_MODS, 8'h00);
    send_req(REQ_KEY, CMD_RESET, 7'h00, 1'b1, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_POWER, 1'b1, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_CAPS, 1'b1, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_CAPS, 1'b0, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_CAPS, 1'b1, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_HELP, 1'b1, 2'd0, 8'h00);
    send_req(REQ_KEY, CMD_RESET, KEY_CLEAR, 1'b1, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_MODS, 8'h00);
    repeat (4) send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_EVENTS, 8'h00);
    send_req(REQ_BUS, CMD_LISTEN, 7'h00, 1'b0, REG_MODS, 8'h00);
    send_req(REQ_LED_DATA, CMD_RESET, 7'h00, 1'b0, 2'd0, 8'hff);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_MODS, 8'h00);
    // led byte with no listen pending is dropped
    send_req(REQ_LED_DATA, CMD_RESET, 7'h00, 1'b0, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_LISTEN, 7'h00, 1'b0, REG_MODS, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_UNUSED1, 8'h00);
    send_req(REQ_LED_DATA, CMD_RESET, 7'h00, 1'b0, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_LISTEN, 7'h00, 1'b0, REG_EVENTS, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_UNUSED3, 8'h00);
    send_req(REQ_RELEASE, CMD_RESET, 7'h00, 1'b0, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_EVENTS, 8'h00);
    send_req(REQ_BUS, CMD_FLUSH, 7'h00, 1'b0, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_EVENTS, 8'h00);
    send_req(REQ_BUS, CMD_RESET, 7'h00, 1'b0, 2'd0, 8'h00);
    send_req(REQ_BUS, CMD_TALK, 7'h00, 1'b0, REG_MODS, 8'h00);
    wait_for_responses();

    while (n_sent < TOTAL_REQS) begin
      if (n_sent >= TOTAL_REQS - QUIET_TAIL) quiet = 1'b1;
      if (!squeezed && n_sent >= SQUEEZE_AT) begin
        // receiver holds off while talk 2 requests pile up behind it
        squeezed = 1'b1;
        hold_out = 1'b1;
        repeat (24) send_req(REQ_BUS, CMD_TALK, pick_key(), 1'($urandom), REG_MODS,
                             8'($urandom_range(0, 255)));
      end else if (n_sent >= PAUSE_AT && n_sent < PAUSE_AT + 2) begin
        wait_for_responses();
        random_req();
      end else begin
        random_req();
      end
    end

    wait_for_responses();
    if (trk.pending_resp.size() != 0) trk.report("responses still outstanding");
    if (trk.errors == 0) begin
      $display("[adb_keyboard_event_device_top] OK");
    end else begin
      $display("[adb_keyboard_event_device_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/adbkbd_pkg.sv
src/adbkbd_ctrl.sv
src/adbkbd_dp.sv
src/adb_keyboard_event_device_top.sv
tb/adb_keyboard_event_device_top_tb.sv
